@@ rtl/brtc_pkg.sv @@
package brtc_pkg;

	localparam int CW        = 64;
	localparam int FRAC_BITS = 8;
	localparam int PCT_SCALE = 100 << FRAC_BITS;
	localparam int KW        = $clog2(PCT_SCALE + 1);
	localparam int QW        = KW;
	localparam int HALF      = CW / 2;
	localparam int NW        = CW + KW;
	localparam int PCT_W     = 15;
	localparam int N_TICKS   = 8;
	localparam int SEL_W     = $clog2(N_TICKS);
	localparam int SUM_TERMS = 6;
	localparam int DIV_CNT_W = $clog2(QW + 1);

	localparam logic [KW-1:0]    K_CONST = KW'(PCT_SCALE);
	localparam logic [PCT_W-1:0] PCT_MAX = {PCT_W{1'b1}};

	localparam logic [1:0] CMD_SAMPLE  = 2'd0;
	localparam logic [1:0] CMD_FAIL    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	localparam logic [1:0] STATUS_UNAVAIL = 2'd0;
	localparam logic [1:0] STATUS_STALE   = 2'd1;
	localparam logic [1:0] STATUS_FRESH   = 2'd2;

	localparam logic [2:0] CAUSE_NONE    = 3'd0;
	localparam logic [2:0] CAUSE_SOURCE  = 3'd1;
	localparam logic [2:0] CAUSE_OVERFLOW = 3'd2;
	localparam logic [2:0] CAUSE_REGRESS = 3'd3;
	localparam logic [2:0] CAUSE_ZERO    = 3'd4;

	typedef enum logic [1:0] {
		RES_FIRST,
		RES_FAIL,
		RES_FRESH
	} res_kind_t;

	typedef struct packed {
		logic             capture;
		logic             sum_step;
		logic [SEL_W-1:0] sum_sel;
		logic             form_total;
		logic             take_delta;
		logic             mul;
		logic             combine;
		logic             div_step;
		logic             clear_base;
		logic             commit_first;
		logic             commit_fresh;
		logic             load_out;
		res_kind_t        out_kind;
		logic [2:0]       out_cause;
	} brtc_cmd_t;

	typedef struct packed {
		logic overflow;
		logic base_valid;
		logic regress;
		logic zero_delta;
	} brtc_status_t;

	function automatic logic [PCT_W-1:0] sat_pct(input logic [QW-1:0] q);
		if (QW > PCT_W && (q >> PCT_W) != '0) begin
			return PCT_MAX;
		end
		return PCT_W'(q);
	endfunction

endpackage

@@ rtl/busy_ratio_from_tick_counters_unit.sv @@
// Busy ratio unit: turns cumulative tick counter samples into a busy percentage.
// The input channel (in_valid, in_ready) carries a command, eight tick counters
// and a timestamp; the output channel (out_valid, out_ready) carries a status,
// the percent in Q7.8, the copied timestamp and a failure cause.
// A counter sample sums six busy counters through one accumulating adder and
// its two idle counters in a second adder, checks overflow, regression and zero
// delta, then scales the busy delta by a 32-bit split multiply and divides by
// the total delta in a restoring divider that retires one quotient bit per cycle.
// The unit takes a new item only once it is back in idle, after the result of
// the last item is loaded into the output register. A first sample or a failed
// check has its result after the checks and a source failure goes straight to
// the final step; a restart or an unused command gives no result and frees the
// unit at once.
// The result sits in an output register, so a stalled receiver does not hold up
// the work on the next item; the unit only waits in its final step when that
// register still holds a result whose transfer has not happened.
// Reset clears the baseline and the last valid percent and empties the output
// register.
module busy_ratio_from_tick_counters_unit
	import brtc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       command,
	input  logic [CW-1:0]    user_ticks,
	input  logic [CW-1:0]    nice_ticks,
	input  logic [CW-1:0]    system_ticks,
	input  logic [CW-1:0]    idle_ticks,
	input  logic [CW-1:0]    iowait_ticks,
	input  logic [CW-1:0]    irq_ticks,
	input  logic [CW-1:0]    softirq_ticks,
	input  logic [CW-1:0]    steal_ticks,
	input  logic [63:0]      sample_time_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       sample_status,
	output logic [PCT_W-1:0] busy_percent,
	output logic [63:0]      sample_time_out,
	output logic [2:0]       failure_cause
);

	brtc_cmd_t    cmd;
	brtc_status_t sts;

	brtc_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.command   (command),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	brtc_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.user_ticks      (user_ticks),
		.nice_ticks      (nice_ticks),
		.system_ticks    (system_ticks),
		.idle_ticks      (idle_ticks),
		.iowait_ticks    (iowait_ticks),
		.irq_ticks       (irq_ticks),
		.softirq_ticks   (softirq_ticks),
		.steal_ticks     (steal_ticks),
		.sample_time_in  (sample_time_in),
		.sample_status   (sample_status),
		.busy_percent    (busy_percent),
		.sample_time_out (sample_time_out),
		.failure_cause   (failure_cause)
	);

endmodule

@@ rtl/brtc_datapath.sv @@
module brtc_datapath
	import brtc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  brtc_cmd_t           cmd,
	output brtc_status_t        sts,
	input  logic [CW-1:0]       user_ticks,
	input  logic [CW-1:0]       nice_ticks,
	input  logic [CW-1:0]       system_ticks,
	input  logic [CW-1:0]       idle_ticks,
	input  logic [CW-1:0]       iowait_ticks,
	input  logic [CW-1:0]       irq_ticks,
	input  logic [CW-1:0]       softirq_ticks,
	input  logic [CW-1:0]       steal_ticks,
	input  logic [63:0]         sample_time_in,
	output logic [1:0]          sample_status,
	output logic [PCT_W-1:0]    busy_percent,
	output logic [63:0]         sample_time_out,
	output logic [2:0]          failure_cause
);

	logic [CW-1:0]      tick_q [N_TICKS];
	logic [63:0]        time_q;
	logic [CW+2:0]      busy_acc_q;
	logic [CW:0]        idle_acc_q;
	logic [CW-1:0]      total_q;
	logic               overflow_q;
	logic [CW-1:0]      d_total_q;
	logic [CW-1:0]      d_busy_q;
	logic [HALF+KW-1:0] prod_lo_q;
	logic [HALF+KW-1:0] prod_hi_q;
	logic [CW-1:0]      rem_q;
	logic [QW-1:0]      low_q;
	logic [QW-1:0]      quot_q;

	logic               base_valid_q;
	logic [CW-1:0]      base_busy_q;
	logic [CW-1:0]      base_idle_q;
	logic [CW-1:0]      base_total_q;
	logic               last_present_q;
	logic [PCT_W-1:0]   last_pct_q;

	logic [1:0]         status_out_q;
	logic [PCT_W-1:0]   pct_out_q;
	logic [63:0]        time_out_q;
	logic [2:0]         cause_out_q;

	logic [CW+3:0]      total_ext;
	logic [NW-1:0]      num;
	logic [CW:0]        trial;
	logic [CW:0]        trial_diff;
	logic               trial_ge;

	assign total_ext  = (CW+4)'(busy_acc_q) + (CW+4)'(idle_acc_q);
	assign num        = NW'(prod_lo_q) + {prod_hi_q, {HALF{1'b0}}};
	assign trial      = {rem_q, low_q[QW-1]};
	assign trial_ge   = trial >= {1'b0, d_total_q};
	assign trial_diff = trial - {1'b0, d_total_q};

	assign sts.overflow   = overflow_q;
	assign sts.base_valid = base_valid_q;
	assign sts.regress    = (total_q < base_total_q) ||
		(idle_acc_q[CW-1:0] < base_idle_q) ||
		(busy_acc_q[CW-1:0] < base_busy_q);
	assign sts.zero_delta = total_q == base_total_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tick_q[0]  <= user_ticks;
			tick_q[1]  <= nice_ticks;
			tick_q[2]  <= system_ticks;
			tick_q[3]  <= irq_ticks;
			tick_q[4]  <= softirq_ticks;
			tick_q[5]  <= steal_ticks;
			tick_q[6]  <= idle_ticks;
			tick_q[7]  <= iowait_ticks;
			time_q     <= sample_time_in;
			busy_acc_q <= '0;
		end else if (cmd.sum_step) begin
			busy_acc_q <= busy_acc_q + (CW+3)'(tick_q[cmd.sum_sel]);
		end
		if (cmd.sum_step) begin
			idle_acc_q <= (CW+1)'(tick_q[6]) + (CW+1)'(tick_q[7]);
		end
		if (cmd.form_total) begin
			total_q    <= total_ext[CW-1:0];
			overflow_q <= total_ext[CW+3:CW] != '0;
		end
		if (cmd.take_delta) begin
			d_total_q <= total_q - base_total_q;
			d_busy_q  <= busy_acc_q[CW-1:0] - base_busy_q;
		end
		if (cmd.mul) begin
			prod_lo_q <= (HALF+KW)'(d_busy_q[HALF-1:0]) * (HALF+KW)'(K_CONST);
			prod_hi_q <= (HALF+KW)'(d_busy_q[CW-1:HALF]) * (HALF+KW)'(K_CONST);
		end
		if (cmd.combine) begin
			rem_q  <= num[NW-1:QW];
			low_q  <= num[QW-1:0];
			quot_q <= '0;
		end else if (cmd.div_step) begin
			low_q <= low_q << 1;
			if (trial_ge) begin
				rem_q  <= trial_diff[CW-1:0];
				quot_q <= {quot_q[QW-2:0], 1'b1};
			end else begin
				rem_q  <= trial[CW-1:0];
				quot_q <= {quot_q[QW-2:0], 1'b0};
			end
		end
		if (cmd.load_out) begin
			time_out_q <= time_q;
			unique case (cmd.out_kind)
				RES_FIRST: begin
					status_out_q <= STATUS_UNAVAIL;
					pct_out_q    <= '0;
				end
				RES_FRESH: begin
					status_out_q <= STATUS_FRESH;
					pct_out_q    <= sat_pct(quot_q);
				end
				default: begin
					status_out_q <= last_present_q ? STATUS_STALE : STATUS_UNAVAIL;
					pct_out_q    <= last_present_q ? last_pct_q : '0;
				end
			endcase
			cause_out_q <= cmd.out_cause;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_valid_q   <= 1'b0;
			base_busy_q    <= '0;
			base_idle_q    <= '0;
			base_total_q   <= '0;
			last_present_q <= 1'b0;
			last_pct_q     <= '0;
		end else begin
			if (cmd.clear_base) begin
				base_valid_q <= 1'b0;
			end
			if (cmd.commit_first || cmd.commit_fresh) begin
				base_valid_q <= 1'b1;
				base_busy_q  <= busy_acc_q[CW-1:0];
				base_idle_q  <= idle_acc_q[CW-1:0];
				base_total_q <= total_q;
			end
			if (cmd.commit_fresh) begin
				last_present_q <= 1'b1;
				last_pct_q     <= sat_pct(quot_q);
			end
		end
	end

	assign sample_status   = status_out_q;
	assign busy_percent    = pct_out_q;
	assign sample_time_out = time_out_q;
	assign failure_cause   = cause_out_q;

	// The partial remainder must stay below the divisor throughout the division.
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < d_total_q)
		else $error("division remainder not below divisor");

	// A fresh percent never exceeds the full scale.
	a_fresh_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_fresh |-> quot_q <= QW'(PCT_SCALE))
		else $error("fresh percent above full scale");

	// Busy delta cannot exceed total delta once the regression check has passed.
	a_busy_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> d_busy_q <= d_total_q)
		else $error("busy delta above total delta");

endmodule

@@ rtl/brtc_controller.sv @@
module brtc_controller
	import brtc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [1:0]   command,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  brtc_status_t sts,
	output brtc_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_TOTAL,
		ST_CHECK,
		ST_DELTA,
		ST_MUL,
		ST_COMBINE,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic [SEL_W-1:0]     step_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	res_kind_t            kind_q;
	logic [2:0]           cause_q;
	logic                 out_valid_q;
	logic                 slot_free;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.sum_sel   = step_q;
		cmd.out_kind  = kind_q;
		cmd.out_cause = cause_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture    = in_valid;
				cmd.clear_base = in_valid && command == CMD_RESTART;
			end
			ST_SUM:     cmd.sum_step   = 1'b1;
			ST_TOTAL:   cmd.form_total = 1'b1;
			ST_DELTA:   cmd.take_delta = 1'b1;
			ST_MUL:     cmd.mul        = 1'b1;
			ST_COMBINE: cmd.combine    = 1'b1;
			ST_DIV:     cmd.div_step   = 1'b1;
			ST_FINISH: begin
				if (slot_free) begin
					cmd.load_out     = 1'b1;
					cmd.commit_first = kind_q == RES_FIRST;
					cmd.commit_fresh = kind_q == RES_FRESH;
					cmd.clear_base   = kind_q == RES_FAIL;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			div_cnt_q   <= '0;
			kind_q      <= RES_FAIL;
			cause_q     <= CAUSE_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (command)
							CMD_SAMPLE: begin
								state_q <= ST_SUM;
								step_q  <= '0;
							end
							CMD_FAIL: begin
								state_q <= ST_FINISH;
								kind_q  <= RES_FAIL;
								cause_q <= CAUSE_SOURCE;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SUM: begin
					if (step_q == SEL_W'(SUM_TERMS - 1)) begin
						state_q <= ST_TOTAL;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_TOTAL: state_q <= ST_CHECK;
				ST_CHECK: begin
					priority if (sts.overflow) begin
						state_q <= ST_FINISH;
						kind_q  <= RES_FAIL;
						cause_q <= CAUSE_OVERFLOW;
					end else if (!sts.base_valid) begin
						state_q <= ST_FINISH;
						kind_q  <= RES_FIRST;
						cause_q <= CAUSE_NONE;
					end else if (sts.regress) begin
						state_q <= ST_FINISH;
						kind_q  <= RES_FAIL;
						cause_q <= CAUSE_REGRESS;
					end else if (sts.zero_delta) begin
						state_q <= ST_FINISH;
						kind_q  <= RES_FAIL;
						cause_q <= CAUSE_ZERO;
					end else begin
						state_q <= ST_DELTA;
					end
				end
				ST_DELTA: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_COMBINE;
				ST_COMBINE: begin
					state_q   <= ST_DIV;
					div_cnt_q <= DIV_CNT_W'(QW);
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == DIV_CNT_W'(1)) begin
						state_q <= ST_FINISH;
						kind_q  <= RES_FRESH;
						cause_q <= CAUSE_NONE;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The result register is only overwritten once its previous transfer has happened.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transfer");

	// A fresh result needs a baseline from an earlier sample.
	a_fresh_needs_base: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_fresh |-> sts.base_valid)
		else $error("fresh result without baseline");

	// A counter sample always starts the summing sequence.
	a_sample_starts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && command == CMD_SAMPLE) |=> state_q == ST_SUM)
		else $error("sample did not start summing");

	// The divider never runs with an exhausted step count.
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_cnt_q != '0)
		else $error("divider step count exhausted");

endmodule
